[sv/assert_macros.svh]
// Concurrent assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cht_pkg.sv]
`timescale 1ns / 1ps

package cht_pkg;

    localparam int TABLE_DEPTH = 16384;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int IN_DATA_W   = 104;
    localparam int IN_USER_W   = 3;
    localparam int OUT_DATA_W  = 16;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_EVAL_LIMIT = 1'b0;
    localparam logic [14:0] EVAL_LIMIT_RST = 15'd30000;

    localparam int DELTA_MAX = 256;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_UPDATE  = 2'd1,
        CMD_CORRECT = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic load;
        logic mul;
        logic sweep;
        logic fin;
    } t_dp_ctl;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

endpackage

[sv/correction_history_table.sv]
`timescale 1ns / 1ps
// Channel     Direction  Payload
// s_axis      in         tdata: pawn_hash, search_score, static_eval, search_depth
//                        tuser: cmd, side_to_move
// m_axis      out        tdata: corrected_eval
// apb         in/out     eval_limit at byte address 0
//
// Update passes through table read, gravity multiply and write back; correct and the
// unused command skip the multiply, and clear runs a sweep that zeroes one row of both
// tables per cycle over each table's single write port.
// After reset the same sweep runs before the first transfer is taken.
// A stalled output holds one result; the next item proceeds until its own result
// needs the output register.

module correction_history_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pawn_hash[63:0], search_score[79:64], static_eval[95:80], search_depth[103:96]
    input  logic [cht_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // cmd[1:0], side_to_move[2]
    input  logic [cht_pkg::IN_USER_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // corrected_eval[15:0]
    output logic [cht_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cht_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cht_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cht_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import cht_pkg::*;

    t_dp_ctl            ctl;
    t_dp_sts            sts;
    t_cmd               in_cmd;
    logic [14:0]        r_eval_limit;
    logic signed [15:0] out_eval;

    assign in_cmd = t_cmd'(s_axis_tuser[1:0]);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EVAL_LIMIT) ? {17'd0, r_eval_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_limit <= EVAL_LIMIT_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_EVAL_LIMIT)) begin
            r_eval_limit <= pwdata[14:0];
        end
    end

    cht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (in_cmd),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    cht_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_in_cmd     (in_cmd),
        .i_in_side    (s_axis_tuser[2]),
        .i_in_hash    (s_axis_tdata[63:0]),
        .i_in_score   (s_axis_tdata[79:64]),
        .i_in_eval    (s_axis_tdata[95:80]),
        .i_in_depth   (s_axis_tdata[103:96]),
        .i_eval_limit (r_eval_limit),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_eval   (out_eval)
    );

    assign m_axis_tdata = out_eval;

endmodule

[sv/cht_ctrl.sv]
`timescale 1ns / 1ps

module cht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  cht_pkg::t_cmd     i_in_cmd,
    output logic              o_in_ready,
    input  cht_pkg::t_dp_sts  i_sts,
    output cht_pkg::t_dp_ctl  o_ctl
);
    import cht_pkg::*;

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_FIN   = 5'b01000,
        ST_CLEAR = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    case (i_in_cmd)
                        CMD_CLEAR:  n_state = ST_CLEAR;
                        CMD_UPDATE: n_state = ST_MUL;
                        default:    n_state = ST_FIN;
                    endcase
                end
            end
            ST_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                o_ctl.fin = 1'b1;
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_FIN;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/cht_dp.sv]
`timescale 1ns / 1ps

module cht_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cht_pkg::t_dp_ctl                i_ctl,
    output cht_pkg::t_dp_sts                o_sts,
    input  cht_pkg::t_cmd                   i_in_cmd,
    input  logic                            i_in_side,
    input  logic [63:0]                     i_in_hash,
    input  logic signed [15:0]              i_in_score,
    input  logic signed [15:0]              i_in_eval,
    input  logic [7:0]                      i_in_depth,
    input  logic [14:0]                     i_eval_limit,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [15:0]              o_out_eval
);
    import cht_pkg::*;

    logic signed [15:0] mem_w [TABLE_DEPTH];
    logic signed [15:0] mem_b [TABLE_DEPTH];

    logic [IDX_W-1:0]   r_clr_addr;
    logic [IDX_W-1:0]   in_idx;
    logic [IDX_W-1:0]   r_idx;
    t_cmd               r_cmd;
    logic               r_side;
    logic signed [15:0] r_eval;
    logic signed [9:0]  r_delta;
    logic signed [9:0]  n_delta;
    logic signed [15:0] r_rd_w;
    logic signed [15:0] r_rd_b;
    logic signed [25:0] r_gprod;
    logic               r_out_valid;
    logic signed [15:0] r_out_eval;
    logic signed [15:0] n_out_eval;

    logic signed [16:0] diff;
    logic signed [25:0] wprod;
    logic signed [25:0] scaled;
    logic signed [15:0] entry;
    logic [8:0]         mag;
    logic signed [25:0] gquot;
    logic signed [16:0] step;
    logic signed [15:0] sum;
    logic signed [16:0] corr;
    logic signed [16:0] cval;
    logic signed [16:0] lim;
    logic               wr_en;
    logic               push;

    assign in_idx = i_in_hash[IDX_W-1:0];
    assign entry  = r_side ? r_rd_b : r_rd_w;

    always_comb begin
        diff   = $signed({i_in_score[15], i_in_score}) - $signed({i_in_eval[15], i_in_eval});
        wprod  = 26'(diff * $signed({1'b0, i_in_depth}));
        scaled = (wprod + (wprod < 0 ? 26'sd7 : 26'sd0)) >>> 3;
        if (scaled > 26'(DELTA_MAX)) begin
            n_delta = 10'(DELTA_MAX);
        end else if (scaled < -26'(DELTA_MAX)) begin
            n_delta = -10'(DELTA_MAX);
        end else begin
            n_delta = scaled[9:0];
        end
    end

    always_comb begin
        mag   = r_delta[9] ? 9'(-r_delta) : r_delta[8:0];
        gquot = (r_gprod + (r_gprod < 0 ? 26'sd1023 : 26'sd0)) >>> 10;
        step  = $signed({{7{r_delta[9]}}, r_delta}) - gquot[16:0];
        sum   = 16'(entry + step[15:0]);
        corr  = ($signed({entry[15], entry}) + (entry < 0 ? 17'sd63 : 17'sd0)) >>> 6;
        cval  = $signed({r_eval[15], r_eval}) + corr;
        lim   = $signed({2'b00, i_eval_limit});
        if (r_cmd != CMD_CORRECT) begin
            n_out_eval = '0;
        end else if (cval > lim) begin
            n_out_eval = lim[15:0];
        end else if (cval < -lim) begin
            n_out_eval = 16'(-lim);
        end else begin
            n_out_eval = cval[15:0];
        end
    end

    assign o_sts.sweep_last = &r_clr_addr;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign wr_en            = i_ctl.fin && (r_cmd == CMD_UPDATE);
    assign push             = i_ctl.fin && o_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep) begin
            mem_w[r_clr_addr] <= '0;
        end else if (wr_en && !r_side) begin
            mem_w[r_idx] <= sum;
        end
        if (i_ctl.load) begin
            r_rd_w <= mem_w[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep) begin
            mem_b[r_clr_addr] <= '0;
        end else if (wr_en && r_side) begin
            mem_b[r_idx] <= sum;
        end
        if (i_ctl.load) begin
            r_rd_b <= mem_b[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_in_cmd;
            r_side  <= i_in_side;
            r_idx   <= in_idx;
            r_eval  <= i_in_eval;
            r_delta <= n_delta;
        end
        if (i_ctl.mul) begin
            r_gprod <= 26'(entry * $signed({1'b0, mag}));
        end
        if (push) begin
            r_out_eval <= n_out_eval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.sweep) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_eval  = r_out_eval;

endmodule

[sv/cht_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cht_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [cht_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                pready
);

    `ASSERT_NXT(a_busy_after_in, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
    `ASSERT_IMP(a_no_min_eval, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata != 16'h8000, "corrected eval out of range")
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
    `ASSERT_IMP(a_pready, i_clk, i_rst_n, 1'b1, pready, "pready dropped")

endmodule

bind correction_history_table cht_checker u_cht_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import cht_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int POOL_SIZE      = 8;
    localparam int DEPTH_DIV      = 8;
    localparam int GRAVITY_DIV    = 1024;
    localparam int CORR_SCALE     = 16;
    localparam logic [63:0] HASH_ONES  = '1;
    localparam logic [63:0] HASH_ALIAS = 64'h8000_0000_0000_3FFF;

    typedef struct {
        t_cmd                  cmd;
        logic [OUT_DATA_W-1:0] corrected_eval;
    } t_eval_expect;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // pawn_hash, search_score, static_eval, search_depth
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // cmd, side_to_move
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // corrected_eval
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic signed [15:0]    side_corrections [2][TABLE_DEPTH];
    logic [14:0]           cur_eval_limit = EVAL_LIMIT_RST;
    t_eval_expect          pending_evals[$];
    logic [IDX_W-1:0]      hash_pool [POOL_SIZE];
    int                    mismatch_count = 0;
    int                    send_run = 0;
    int                    recv_run = 0;

    correction_history_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [15:0] sat16(input int v);
        return 16'(clamp_int(v, -32768, 32767));
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [15:0] predict_corrected_eval(input t_cmd cmd, input logic side,
                                                           input logic [63:0] hash,
                                                           input logic signed [15:0] score,
                                                           input logic signed [15:0] eval,
                                                           input logic [7:0] depth);
        int idx;
        int entry;
        int delta;
        int mag;
        int gravity_step;
        int corr;
        int lim;
        int res;
        idx = int'(hash % 64'(TABLE_DEPTH));
        entry = int'(side_corrections[side][idx]);
        res = 0;
        case (cmd)
            CMD_CLEAR: begin
                foreach (side_corrections[s, i]) side_corrections[s][i] = '0;
            end
            CMD_UPDATE: begin
                delta = (int'(score) - int'(eval)) * int'(depth) / DEPTH_DIV;
                delta = clamp_int(delta, -DELTA_MAX, DELTA_MAX);
                mag = (delta < 0) ? -delta : delta;
                gravity_step = delta - entry * mag / GRAVITY_DIV;
                side_corrections[side][idx] = 16'(entry + gravity_step);
            end
            CMD_CORRECT: begin
                corr = CORR_SCALE * entry / GRAVITY_DIV;
                lim = int'(cur_eval_limit);
                res = clamp_int(int'(eval) + corr, -lim, lim);
            end
            default: res = 0;
        endcase
        return 16'(res);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_item(input t_cmd cmd, input logic side, input logic [63:0] hash,
                             input logic [15:0] score, input logic [15:0] eval,
                             input logic [7:0] depth);
        int gap;
        t_eval_expect want;
        gap = draw_wait(send_run);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {depth, eval, score, hash};
        s_axis_tuser  = {side, cmd};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        want.cmd = cmd;
        want.corrected_eval = predict_corrected_eval(cmd, side, hash, score, eval, depth);
        pending_evals.push_back(want);
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_evals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_eval_limit(input logic [14:0] value);
        wait_results();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(4 * int'(REG_EVAL_LIMIT));
        pwdata  = APB_DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        cur_eval_limit = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Receive side: stall, then take one transfer and compare it.
    initial begin
        int stall;
        t_eval_expect want;
        @(negedge i_clk);
        forever begin
            stall = draw_wait(recv_run);
            if (stall != 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            if (pending_evals.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing pending", m_axis_tdata));
            end else begin
                want = pending_evals.pop_front();
                if (m_axis_tdata !== want.corrected_eval)
                    report_mismatch($sformatf("%s: corrected_eval %h, expected %h",
                                              want.cmd.name(), m_axis_tdata,
                                              want.corrected_eval));
            end
            @(negedge i_clk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    task automatic test_after_reset();
        send_item(CMD_CORRECT, 1'b0, 64'd0, 16'sd0, 16'sd32767, 8'd0);
        send_item(CMD_CORRECT, 1'b1, HASH_ONES, 16'sd0, -16'sd32767, 8'd0);
        send_item(CMD_CORRECT, 1'b0, HASH_ONES, 16'sd0, 16'h8000, 8'd0);
        send_item(CMD_CORRECT, 1'b1, 64'd0, 16'sd0, 16'sd0, 8'd0);
        send_item(CMD_NONE, 1'b1, HASH_ONES, 16'h8000, 16'sd32767, 8'd255);
    endtask

    task automatic test_update_extremes();
        repeat (3) send_item(CMD_UPDATE, 1'b1, HASH_ONES, 16'sd32767, 16'h8000, 8'd255);
        repeat (3) send_item(CMD_UPDATE, 1'b0, 64'd0, 16'h8000, 16'sd32767, 8'd255);
        send_item(CMD_CORRECT, 1'b1, HASH_ALIAS, 16'sd0, 16'sd0, 8'd0);
        send_item(CMD_CORRECT, 1'b0, 64'd0, 16'sd0, 16'sd0, 8'd0);
        send_item(CMD_CORRECT, 1'b0, HASH_ONES, 16'sd0, 16'sd100, 8'd0);
        send_item(CMD_UPDATE, 1'b0, 64'd5, 16'sd32767, -16'sd32767, 8'd0);
        send_item(CMD_UPDATE, 1'b0, 64'd5, 16'sd5, 16'sd0, 8'd3);
        send_item(CMD_UPDATE, 1'b1, 64'd5, 16'sd0, 16'sd5, 8'd3);
        send_item(CMD_CORRECT, 1'b0, 64'd5, 16'sd0, 16'sd0, 8'd0);
        send_item(CMD_CORRECT, 1'b1, 64'd5, 16'sd0, 16'sd0, 8'd0);
        send_item(CMD_NONE, 1'b1, HASH_ONES, 16'sd32767, 16'h8000, 8'd255);
        send_item(CMD_CORRECT, 1'b1, HASH_ONES, 16'sd0, 16'sd0, 8'd0);
    endtask

    task automatic test_clear();
        send_item(CMD_CLEAR, 1'b0, 64'd0, 16'sd0, 16'sd0, 8'd0);
        send_item(CMD_CORRECT, 1'b1, HASH_ONES, 16'sd0, 16'sd0, 8'd0);
        send_item(CMD_CORRECT, 1'b0, 64'd0, 16'sd0, 16'sd0, 8'd0);
    endtask

    task automatic test_eval_limits();
        repeat (2) send_item(CMD_UPDATE, 1'b0, 64'd7, 16'sd32767, 16'h8000, 8'd255);
        repeat (2) send_item(CMD_UPDATE, 1'b1, 64'd7, 16'h8000, 16'sd32767, 8'd255);
        set_eval_limit(15'd0);
        send_item(CMD_CORRECT, 1'b0, 64'd7, 16'sd0, 16'sd32767, 8'd0);
        send_item(CMD_CORRECT, 1'b1, 64'd7, 16'sd0, 16'h8000, 8'd0);
        set_eval_limit(15'd32767);
        send_item(CMD_CORRECT, 1'b0, 64'd7, 16'sd0, 16'sd32767, 8'd0);
        send_item(CMD_CORRECT, 1'b1, 64'd7, 16'sd0, 16'h8000, 8'd0);
        send_item(CMD_CORRECT, 1'b1, 64'd7, 16'sd0, 16'h8000, 8'd0);
        set_eval_limit(15'd1);
        send_item(CMD_CORRECT, 1'b0, 64'd7, 16'sd0, -16'sd50, 8'd0);
    endtask

    function automatic logic [63:0] pool_hash(input int slot);
        logic [63:0] h;
        h = {$urandom, $urandom};
        h[IDX_W-1:0] = hash_pool[slot];
        return h;
    endfunction

    function automatic t_cmd pick_cmd();
        case ($urandom_range(0, 9))
            0:          return CMD_NONE;
            1, 2, 3, 4: return CMD_UPDATE;
            default:    return CMD_CORRECT;
        endcase
    endfunction

    task automatic test_random(input int n_items, input logic [14:0] limit);
        int sent;
        int r;
        int k;
        int slot;
        int sign;
        logic side;
        logic [15:0] ev;
        t_cmd cmd;
        set_eval_limit(limit);
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            side = 1'($urandom_range(0, 1));
            slot = $urandom_range(0, POOL_SIZE - 1);
            if (r < 70) begin
                // push one entry in one direction, then read it back
                k = $urandom_range(1, 6);
                sign = $urandom_range(0, 1) ? 1 : -1;
                repeat (k) begin
                    ev = rand16();
                    send_item(CMD_UPDATE, side, pool_hash(slot),
                              sat16(int'($signed(ev)) + sign * $urandom_range(0, 6000)),
                              ev, 8'($urandom_range(0, 255)));
                end
                send_item(CMD_CORRECT, side, pool_hash(slot), rand16(), rand16(),
                          8'($urandom_range(0, 255)));
                sent += k + 1;
            end else if (r < 95) begin
                send_item(pick_cmd(), side, pool_hash(slot), rand16(), rand16(),
                          8'($urandom_range(0, 255)));
                sent++;
            end else begin
                cmd = ($urandom_range(0, 7) == 0) ? CMD_CLEAR : pick_cmd();
                send_item(cmd, side, {$urandom, $urandom}, rand16(), rand16(),
                          8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial begin
        foreach (side_corrections[s, i]) side_corrections[s][i] = '0;
        hash_pool[0] = '0;
        hash_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) hash_pool[i] = IDX_W'($urandom);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_after_reset();
        test_update_extremes();
        test_clear();
        test_eval_limits();
        test_random(210, 15'($urandom_range(0, 32767)));
        test_random(210, 15'($urandom_range(0, 20)));
        test_random(210, 15'd32767);
        test_random(210, EVAL_LIMIT_RST);

        wait_results();
        if (pending_evals.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_evals.size()));
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
